// ===== src/random_sphere_velocity_rotate_assert.svh =====
// ---------------------------------------------------------------------------
// random_sphere_velocity_rotate assertion macros
// shared property forms, clocked on clk and disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef RANDOM_SPHERE_VELOCITY_ROTATE_ASSERT_SVH
`define RANDOM_SPHERE_VELOCITY_ROTATE_ASSERT_SVH

// same-cycle implication
`define RSVR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RSVR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rsvr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsvr_pkg
// types, constants and helpers for the spherical velocity generator
// ---------------------------------------------------------------------------
package rsvr_pkg;

	localparam int FIELD_W      = 16;
	localparam int ANG_W        = 18;
	localparam int TRIG_W       = 18;
	localparam int VEL_W        = 27;
	localparam int MAT_W        = 34;
	localparam int OUT_W        = 20;
	localparam int CORDIC_STEPS = 28;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_PTR_W   = 2;

	localparam longint Q30_PI      = 64'sd3373259426;
	localparam longint Q30_TWO_PI  = 64'sd6746518852;
	localparam longint Q30_HALF_PI = 64'sd1686629713;
	localparam longint CORDIC_GAIN = 64'sd652032874;

	typedef enum logic [2:0] {
		REG_MAG_MIN = 3'd0,
		REG_MAG_MAX = 3'd1,
		REG_AZ_MIN  = 3'd2,
		REG_AZ_MAX  = 3'd3,
		REG_POL_MIN = 3'd4,
		REG_POL_MAX = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic        [15:0] mag_min;
		logic        [15:0] mag_max;
		logic signed [15:0] az_min;
		logic signed [15:0] az_max;
		logic signed [15:0] pol_min;
		logic signed [15:0] pol_max;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] qz;
		logic signed [15:0] qy;
		logic signed [15:0] qx;
		logic signed [15:0] qw;
	} quat_t;

	// raw request fields as they arrive
	typedef struct packed {
		quat_t       quat;
		logic [15:0] frac_mag;
		logic [15:0] frac_pol;
		logic [15:0] frac_az;
		logic [15:0] index;
	} raw_t;

	// request after range mapping, magnitude can reach twice the 16-bit range
	typedef struct packed {
		quat_t                    quat;
		logic        [16:0]       mag;
		logic signed [ANG_W-1:0]  phi;
		logic signed [ANG_W-1:0]  theta;
	} item_t;

	// floor((prod + 32767) / 65535) for prod below 2^32 - 32767
	function automatic logic [15:0] div_by_max(input logic [31:0] prod);
		logic [31:0] x;
		logic [15:0] q0;
		logic [16:0] rem;
		logic [16:0] q;
		x   = prod + 32'd32767;
		q0  = x[31:16];
		rem = {1'b0, x[15:0]} + {1'b0, q0};
		q   = {1'b0, q0} + ((rem >= 17'd65535) ? 17'd1 : 17'd0)
			+ ((rem >= 17'd131070) ? 17'd1 : 17'd0);
		return q[15:0];
	endfunction

	function automatic logic [15:0] abs_diff_s(input logic signed [15:0] a,
			input logic signed [15:0] b);
		logic signed [16:0] d;
		d = {a[15], a} - {b[15], b};
		return d[16] ? 16'(-d) : d[15:0];
	endfunction

	function automatic logic [15:0] abs_diff_u(input logic [15:0] a, input logic [15:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// arctangent of 2^-i in Q30
	function automatic longint cordic_atan(input int i);
		longint r;
		unique case (i)
			0:       r = 64'sd843314857;
			1:       r = 64'sd497837829;
			2:       r = 64'sd263043837;
			3:       r = 64'sd133525159;
			4:       r = 64'sd67021687;
			5:       r = 64'sd33543516;
			6:       r = 64'sd16775851;
			7:       r = 64'sd8388437;
			8:       r = 64'sd4194283;
			9:       r = 64'sd2097149;
			10:      r = 64'sd1048576;
			default: r = 64'sd1 <<< (30 - i);
		endcase
		return r;
	endfunction

endpackage

// ===== src/random_sphere_velocity_rotate.sv =====
`timescale 1ns / 1ps
// Takes one particle request per cycle while the result side keeps taking, and returns one
// rotated velocity per request, in order. A request passes the intake stages, the queue, the
// angle pipeline (31 + RED stages, RED = 18 - ANGLE_FRAC_BITS below 16 fraction bits,
// otherwise 2; 37 at the default) and 6 vector and rotation stages. The angle pipeline
// holds one modulo reduction step or one cordic iteration per stage, so the sustained rate
// is one particle per clock while the result side keeps taking.
// ---------------------------------------------------------------------------
// random_sphere_velocity_rotate
// random spherical velocity generator with emitter rotation, top level
// ---------------------------------------------------------------------------
module random_sphere_velocity_rotate #(
	parameter int INDEX_BITS      = 16,
	parameter int ANGLE_FRAC_BITS = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// particle_index, frac_azimuth, frac_polar, frac_magnitude, quat_w, quat_x, quat_y, quat_z
	input  logic [127:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_index, vel_x, vel_y, vel_z, 4 zero bits
	output logic [79:0]  m_axis_tdata
);

	localparam int FW = $bits(rsvr_pkg::item_t) + INDEX_BITS;

	rsvr_pkg::cfg_t  cfg_q;
	rsvr_pkg::raw_t  raw;
	rsvr_pkg::item_t f_item, b_item;
	logic [INDEX_BITS-1:0] f_idx, b_idx, o_idx;
	logic f_valid, f_ready, b_valid, b_ready;
	logic [FW-1:0] q_data;
	logic signed [rsvr_pkg::OUT_W-1:0] vel [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mag_min <= 16'd0;
			cfg_q.mag_max <= 16'd256;
			cfg_q.az_min  <= 16'sd0;
			cfg_q.az_max  <= 16'sd25736;
			cfg_q.pol_min <= 16'sd0;
			cfg_q.pol_max <= 16'sd12868;
		end else if (cfg_we) begin
			unique case (rsvr_pkg::cfg_reg_t'(cfg_index))
				rsvr_pkg::REG_MAG_MIN: cfg_q.mag_min <= cfg_wdata;
				rsvr_pkg::REG_MAG_MAX: cfg_q.mag_max <= cfg_wdata;
				rsvr_pkg::REG_AZ_MIN:  cfg_q.az_min  <= $signed(cfg_wdata);
				rsvr_pkg::REG_AZ_MAX:  cfg_q.az_max  <= $signed(cfg_wdata);
				rsvr_pkg::REG_POL_MIN: cfg_q.pol_min <= $signed(cfg_wdata);
				rsvr_pkg::REG_POL_MAX: cfg_q.pol_max <= $signed(cfg_wdata);
				default:               cfg_q <= cfg_q;
			endcase
		end
	end

	assign raw = rsvr_pkg::raw_t'(s_axis_tdata);

	rsvr_front #(.IDX_W(INDEX_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_raw(raw),
		.out_valid(f_valid), .out_ready(f_ready), .out_item(f_item), .out_idx(f_idx)
	);

	rsvr_fifo #(.W(FW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data({f_item, f_idx}),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(q_data)
	);

	assign {b_item, b_idx} = q_data;

	rsvr_back #(.IDX_W(INDEX_BITS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(b_valid), .in_ready(b_ready), .in_item(b_item), .in_idx(b_idx),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_idx(o_idx), .out_vel(vel)
	);

	assign m_axis_tdata = {4'b0000, vel[2], vel[1], vel[0], 16'(o_idx)};

endmodule

// ===== src/rsvr_trig.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsvr_trig
// pipelined cosine and sine: modulo two pi reduction, quadrant fold, cordic
// ---------------------------------------------------------------------------
module rsvr_trig #(
	parameter int ANGLE_FRAC_BITS = 12,
	parameter int SB_W            = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic signed [rsvr_pkg::ANG_W-1:0]  ang,
	input  logic        [SB_W-1:0]             sb_in,
	output logic signed [rsvr_pkg::TRIG_W-1:0] cos_o,
	output logic signed [rsvr_pkg::TRIG_W-1:0] sin_o,
	output logic        [SB_W-1:0]             sb_out
);

	localparam int RED_TOP = (ANGLE_FRAC_BITS < 16) ? 17 - ANGLE_FRAC_BITS : 1;
	localparam int RED_N   = RED_TOP + 1;
	localparam int U_W     = RED_TOP + 35;
	localparam int SH      = 30 - ANGLE_FRAC_BITS;
	localparam int CW      = 35;
	localparam int NS      = rsvr_pkg::CORDIC_STEPS;

	localparam logic signed [U_W:0] OFS = (U_W+1)'(rsvr_pkg::Q30_PI)
		+ ((U_W+1)'(rsvr_pkg::Q30_TWO_PI) <<< RED_TOP);
	localparam logic signed [CW-1:0] PI_C   = CW'(rsvr_pkg::Q30_PI);
	localparam logic signed [CW-1:0] HALF_C = CW'(rsvr_pkg::Q30_HALF_PI);
	localparam logic signed [CW-1:0] GAIN_C = CW'(rsvr_pkg::CORDIC_GAIN);

	logic signed [U_W:0]    a_ext;
	logic signed [U_W:0]    u_sum;
	logic        [U_W-1:0]  u_q  [0:RED_N];
	logic        [SB_W-1:0] sb_u_q [0:RED_N];

	logic signed [CW-1:0]   a_m;
	logic signed [CW-1:0]   a_f;
	logic                   neg_f;

	logic signed [CW-1:0]   x_q  [0:NS];
	logic signed [CW-1:0]   y_q  [0:NS];
	logic signed [CW-1:0]   z_q  [0:NS];
	logic                   neg_q [0:NS];
	logic        [SB_W-1:0] sb_c_q [0:NS];

	logic signed [CW-1:0]   xn, yn, xr, yr;
	logic signed [rsvr_pkg::TRIG_W-1:0] cos_q, sin_q;
	logic        [SB_W-1:0] sb_o_q;

	// bias by pi plus a multiple of two pi so the restoring reduction sees a positive value
	assign a_ext = (U_W+1)'(ang) <<< SH;
	assign u_sum = a_ext + OFS;

	always_ff @(posedge clk) begin
		if (en) begin
			u_q[0] <= u_sum[U_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_u_q[0] <= '0;
		end else if (en) begin
			sb_u_q[0] <= sb_in;
		end
	end

	for (genvar k = 0; k < RED_N; k++) begin : g_red
		localparam logic [U_W-1:0] STEP = U_W'(rsvr_pkg::Q30_TWO_PI) << (RED_TOP - k);
		always_ff @(posedge clk) begin
			if (en) begin
				u_q[k+1] <= (u_q[k] >= STEP) ? u_q[k] - STEP : u_q[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sb_u_q[k+1] <= '0;
			end else if (en) begin
				sb_u_q[k+1] <= sb_u_q[k];
			end
		end
	end

	// back to [-pi, pi), then fold into [-pi/2, pi/2] with a sign flip
	assign a_m = $signed({2'b00, u_q[RED_N][32:0]}) - PI_C;

	always_comb begin
		priority if (a_m > HALF_C) begin
			a_f   = a_m - PI_C;
			neg_f = 1'b1;
		end else if (a_m < -HALF_C) begin
			a_f   = a_m + PI_C;
			neg_f = 1'b1;
		end else begin
			a_f   = a_m;
			neg_f = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]   <= GAIN_C;
			y_q[0]   <= '0;
			z_q[0]   <= a_f;
			neg_q[0] <= neg_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_c_q[0] <= '0;
		end else if (en) begin
			sb_c_q[0] <= sb_u_q[RED_N];
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		localparam logic signed [CW-1:0] AT = CW'(rsvr_pkg::cordic_atan(i));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_q[i][CW-1]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - AT;
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + AT;
				end
				neg_q[i+1] <= neg_q[i];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sb_c_q[i+1] <= '0;
			end else if (en) begin
				sb_c_q[i+1] <= sb_c_q[i];
			end
		end
	end

	assign xn = neg_q[NS] ? -x_q[NS] : x_q[NS];
	assign yn = neg_q[NS] ? -y_q[NS] : y_q[NS];
	assign xr = (xn + CW'(8192)) >>> 14;
	assign yr = (yn + CW'(8192)) >>> 14;

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= xr[rsvr_pkg::TRIG_W-1:0];
			sin_q <= yr[rsvr_pkg::TRIG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_o_q <= '0;
		end else if (en) begin
			sb_o_q <= sb_c_q[NS];
		end
	end

	assign cos_o  = cos_q;
	assign sin_o  = sin_q;
	assign sb_out = sb_o_q;

endmodule

// ===== src/rsvr_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsvr_front
// request intake: maps the three fractions onto their configured ranges
// ---------------------------------------------------------------------------
module rsvr_front #(
	parameter int IDX_W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rsvr_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rsvr_pkg::raw_t       in_raw,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rsvr_pkg::item_t      out_item,
	output logic [IDX_W-1:0]     out_idx
);

	logic [15:0] az_span, pol_span, mag_span;

	logic                  v_s1, v_s2;
	logic [31:0]           paz_s1, ppol_s1, pmag_s1;
	rsvr_pkg::quat_t       quat_s1;
	logic [IDX_W-1:0]      idx_s1, idx_s2;
	rsvr_pkg::item_t       item_s2;
	logic                  en;

	assign en       = !v_s2 || out_ready;
	assign in_ready = en;

	// spans taken straight from the registers so a request right after a write sees it
	assign az_span  = rsvr_pkg::abs_diff_s(cfg.az_max, cfg.az_min);
	assign pol_span = rsvr_pkg::abs_diff_s(cfg.pol_max, cfg.pol_min);
	assign mag_span = rsvr_pkg::abs_diff_u(cfg.mag_max, cfg.mag_min);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			paz_s1  <= in_raw.frac_az * az_span;
			ppol_s1 <= in_raw.frac_pol * pol_span;
			pmag_s1 <= in_raw.frac_mag * mag_span;
			quat_s1 <= in_raw.quat;
			idx_s1  <= IDX_W'(in_raw.index);

			item_s2.theta <= {{2{cfg.az_min[15]}}, cfg.az_min}
				+ $signed({2'b00, rsvr_pkg::div_by_max(paz_s1)});
			item_s2.phi   <= {{2{cfg.pol_min[15]}}, cfg.pol_min}
				+ $signed({2'b00, rsvr_pkg::div_by_max(ppol_s1)});
			item_s2.mag   <= 17'(cfg.mag_min) + 17'(rsvr_pkg::div_by_max(pmag_s1));
			item_s2.quat  <= quat_s1;
			idx_s2        <= idx_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;
	assign out_idx   = idx_s2;

endmodule

// ===== src/rsvr_fifo.sv =====
`timescale 1ns / 1ps
`include "random_sphere_velocity_rotate_assert.svh"
// ---------------------------------------------------------------------------
// rsvr_fifo
// short register queue between the intake and the datapath
// ---------------------------------------------------------------------------
module rsvr_fifo #(
	parameter int W = 96
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);

	localparam int DEPTH = rsvr_pkg::FIFO_DEPTH;
	localparam int PTR_W = rsvr_pkg::FIFO_PTR_W;

	logic [W-1:0]   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             push, pop;

	assign wr_ready = (cnt_q != PTR_W'(0) + (PTR_W+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`RSVR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= (PTR_W+1)'(DEPTH), "fifo count overflow")
	`RSVR_ASSERT_NOW(a_ptr_gap, 1'b1, PTR_W'(wr_ptr_q - rd_ptr_q) == cnt_q[PTR_W-1:0], "ptr gap")
	`RSVR_ASSERT_NXT(a_push_only, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "fifo push lost")
	`RSVR_ASSERT_NXT(a_pop_only, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "fifo pop lost")

endmodule

// ===== src/rsvr_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsvr_back
// datapath: trig of both angles, spherical vector, rotation, saturation
// ---------------------------------------------------------------------------
module rsvr_back #(
	parameter int IDX_W           = 16,
	parameter int ANGLE_FRAC_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rsvr_pkg::item_t      in_item,
	input  logic [IDX_W-1:0]     in_idx,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [IDX_W-1:0]     out_idx,
	output logic signed [rsvr_pkg::OUT_W-1:0] out_vel [3]
);

	localparam int TW  = rsvr_pkg::TRIG_W;
	localparam int VW  = rsvr_pkg::VEL_W;
	localparam int MW  = rsvr_pkg::MAT_W;
	localparam int OW  = rsvr_pkg::OUT_W;
	localparam int PSB = 17 + $bits(rsvr_pkg::quat_t) + IDX_W;

	logic en;
	logic v_t;
	logic [PSB-1:0] sb_p;
	logic signed [TW-1:0] ct, st, cp, sp;
	logic [16:0] mag_t;
	rsvr_pkg::quat_t q_t;
	logic [IDX_W-1:0] idx_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;

	logic signed [34:0] pct_s1, pst_s1, pcz_s1;
	logic signed [TW-1:0] sp_s1;
	logic signed [31:0] qxx_s1, qyy_s1, qzz_s1, qxy_s1, qxz_s1, qyz_s1;
	logic signed [31:0] qwx_s1, qwy_s1, qwz_s1;

	logic signed [52:0] vxf_s2, vyf_s2;
	logic signed [34:0] vzr;
	logic signed [VW-1:0] vz_s2;
	logic signed [MW-1:0] m_s2 [3][3];

	logic signed [52:0] vxr, vyr;
	logic signed [VW-1:0] v_s3v [3];
	logic signed [MW-1:0] m_s3 [3][3];

	logic signed [44:0] hi_s4 [3][3];
	logic signed [44:0] lo_s4 [3][3];
	logic signed [62:0] t_s5 [3][3];

	logic signed [63:0] acc [3];
	logic signed [63:0] rnd [3];
	logic signed [OW-1:0] vel_s6 [3];

	assign en       = !v_s6 || out_ready;
	assign in_ready = en;

	rsvr_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .SB_W(1)) u_trig_az (
		.clk(clk), .arst_n(arst_n), .en(en),
		.ang(in_item.theta), .sb_in(in_valid),
		.cos_o(ct), .sin_o(st), .sb_out(v_t)
	);

	rsvr_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .SB_W(PSB)) u_trig_pol (
		.clk(clk), .arst_n(arst_n), .en(en),
		.ang(in_item.phi), .sb_in({in_item.mag, in_item.quat, in_idx}),
		.cos_o(cp), .sin_o(sp), .sb_out(sb_p)
	);

	assign {mag_t, q_t, idx_t} = sb_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_t;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign vzr = (pcz_s1 + 35'sd128) >>> 8;
	assign vxr = (vxf_s2 + 53'sh800000) >>> 24;
	assign vyr = (vyf_s2 + 53'sh800000) >>> 24;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			acc[j] = 64'(t_s5[j][0]) + 64'(t_s5[j][1]) + 64'(t_s5[j][2]);
			rnd[j] = (acc[j] + 64'sh800000000) >>> 36;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// magnitude by trig products, quaternion products
			pct_s1 <= $signed({1'b0, mag_t}) * ct;
			pst_s1 <= $signed({1'b0, mag_t}) * st;
			pcz_s1 <= $signed({1'b0, mag_t}) * cp;
			sp_s1  <= sp;
			qxx_s1 <= q_t.qx * q_t.qx;
			qyy_s1 <= q_t.qy * q_t.qy;
			qzz_s1 <= q_t.qz * q_t.qz;
			qxy_s1 <= q_t.qx * q_t.qy;
			qxz_s1 <= q_t.qx * q_t.qz;
			qyz_s1 <= q_t.qy * q_t.qz;
			qwx_s1 <= q_t.qw * q_t.qx;
			qwy_s1 <= q_t.qw * q_t.qy;
			qwz_s1 <= q_t.qw * q_t.qz;
			idx_s1 <= idx_t;

			vxf_s2 <= pct_s1 * sp_s1;
			vyf_s2 <= pst_s1 * sp_s1;
			vz_s2  <= vzr[VW-1:0];
			// column layout: m[j][i] weighs v_i in output j
			m_s2[0][0] <= 34'sh10000000 - ((qyy_s1 + qzz_s1) <<< 1);
			m_s2[0][1] <= (qxy_s1 + qwz_s1) <<< 1;
			m_s2[0][2] <= (qxz_s1 - qwy_s1) <<< 1;
			m_s2[1][0] <= (qxy_s1 - qwz_s1) <<< 1;
			m_s2[1][1] <= 34'sh10000000 - ((qxx_s1 + qzz_s1) <<< 1);
			m_s2[1][2] <= (qyz_s1 + qwx_s1) <<< 1;
			m_s2[2][0] <= (qxz_s1 + qwy_s1) <<< 1;
			m_s2[2][1] <= (qyz_s1 - qwx_s1) <<< 1;
			m_s2[2][2] <= 34'sh10000000 - ((qxx_s1 + qyy_s1) <<< 1);
			idx_s2 <= idx_s1;

			v_s3v[0] <= vxr[VW-1:0];
			v_s3v[1] <= vyr[VW-1:0];
			v_s3v[2] <= vz_s2;
			m_s3     <= m_s2;
			idx_s3   <= idx_s2;

			// matrix entry split in two halves to keep multipliers narrow
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					hi_s4[j][i] <= v_s3v[i] * $signed(m_s3[j][i][MW-1:17]);
					lo_s4[j][i] <= v_s3v[i] * $signed({1'b0, m_s3[j][i][16:0]});
				end
			end
			idx_s4 <= idx_s3;

			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					t_s5[j][i] <= (63'(hi_s4[j][i]) <<< 17) + 63'(lo_s4[j][i]);
				end
			end
			idx_s5 <= idx_s4;

			for (int j = 0; j < 3; j++) begin
				priority if (rnd[j] > 64'sd524287) begin
					vel_s6[j] <= 20'sd524287;
				end else if (rnd[j] < -64'sd524288) begin
					vel_s6[j] <= -20'sd524288;
				end else begin
					vel_s6[j] <= rnd[j][OW-1:0];
				end
			end
			idx_s6 <= idx_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_idx   = idx_s6;
	assign out_vel   = vel_s6;

endmodule
